### hdl/ril_pkg.sv
// ----------------------------------------------------------------------------
// ril_pkg: shared types and codes for the reorderable ID list
// Operation and status codes, and the per-cycle command a cell row sees.
// ----------------------------------------------------------------------------
package ril_pkg;

    localparam int MODE_W   = 4;
    localparam int STATUS_W = 3;

    typedef enum logic [MODE_W-1:0] {
        OP_APPEND  = 4'd0,
        OP_PREPEND = 4'd1,
        OP_INSERT  = 4'd2,
        OP_FWD     = 4'd3,
        OP_BACK    = 4'd4,
        OP_FRONT   = 4'd5,
        OP_TAIL    = 4'd6,
        OP_SWAP    = 4'd7,
        OP_DELETE  = 4'd8,
        OP_LIST    = 4'd9
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_MISSING  = 3'd2,
        ST_DUP      = 3'd3,
        ST_AT_TOP   = 3'd4,
        ST_AT_BOT   = 3'd5,
        ST_FULL     = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY,
        S_RESULT,
        S_LIST
    } state_t;

    // Row-wide edit command. Each cell compares its own index to the bounds.
    typedef enum logic [2:0] {
        ED_NONE,
        ED_OPEN,     // shift up from lo..count-1, write id at lo
        ED_DOWN,     // cells lo..hi-1 take right neighbor, hi takes held value
        ED_UP,       // cells lo+1..hi take left neighbor, lo takes held value
        ED_SWAP,     // cell lo takes id_b, cell hi takes id_a
        ED_ROTATE    // list walk: cells below hi take right neighbor, hi takes cell 0
    } edit_t;

endpackage

### hdl/ril_cell.sv
// ----------------------------------------------------------------------------
// ril_cell: one list slot
// Holds one ID, reports a match, and loads from a neighbor or the row command.
// ----------------------------------------------------------------------------
module ril_cell #(
    parameter int IDX_W    = 4,
    parameter int ID_WIDTH = 8
) (
    input  logic                aclk,
    input  logic [IDX_W-1:0]    my_idx,
    input  logic                in_use,
    input  ril_pkg::edit_t      edit,
    input  logic [IDX_W-1:0]    lo,
    input  logic [IDX_W-1:0]    hi,
    input  logic [ID_WIDTH-1:0] wr_id,
    input  logic [ID_WIDTH-1:0] alt_id,
    input  logic [ID_WIDTH-1:0] key_a,
    input  logic [ID_WIDTH-1:0] key_b,
    input  logic [ID_WIDTH-1:0] left_id,
    input  logic [ID_WIDTH-1:0] right_id,
    output logic [ID_WIDTH-1:0] id_out,
    output logic                hit_a,
    output logic                hit_b
);

    logic [ID_WIDTH-1:0] id_reg;
    logic [ID_WIDTH-1:0] id_next;

    assign id_out = id_reg;
    assign hit_a  = in_use && (id_reg == key_a);
    assign hit_b  = in_use && (id_reg == key_b);

    always_comb begin
        id_next = id_reg;
        case (edit)
            ril_pkg::ED_OPEN: begin
                if (my_idx == lo) id_next = wr_id;
                else if (my_idx > lo && in_use) id_next = left_id;
                else if (my_idx > lo && my_idx == hi) id_next = left_id;
            end
            ril_pkg::ED_DOWN: begin
                if (my_idx == hi) id_next = wr_id;
                else if (my_idx >= lo && my_idx < hi) id_next = right_id;
            end
            ril_pkg::ED_UP: begin
                if (my_idx == lo) id_next = wr_id;
                else if (my_idx > lo && my_idx <= hi) id_next = left_id;
            end
            ril_pkg::ED_SWAP: begin
                if (my_idx == lo) id_next = alt_id;
                else if (my_idx == hi) id_next = wr_id;
            end
            ril_pkg::ED_ROTATE: begin
                if (my_idx == hi) id_next = wr_id;
                else if (my_idx < hi) id_next = right_id;
            end
            default: id_next = id_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg <= id_next;
    end

endmodule

### hdl/reorderable_id_list.sv
// ----------------------------------------------------------------------------
// reorderable_id_list: ordered list of unique IDs
// Command stream in, status stream out; the list lives in a row of cells.
// ----------------------------------------------------------------------------
// Each command passes three states after acceptance. The cell row compares
// both IDs in parallel and the control registers the match positions, the
// row applies the edit while the status is registered, and the result
// state then raises m_tvalid. A new command is taken only once the
// previous result has been taken. A list command walks the row by
// rotating it one cell per output transaction, so it yields count
// transactions (one when empty), one per cycle while the receiver keeps
// up, and leaves the order as it found it. One command is in flight at a
// time. No clearing pass is needed after reset: only the state, the entry
// count and the output valid flag are cleared.
module reorderable_id_list #(
    parameter int DEPTH    = 16,
    parameter int ID_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // mode[3:0], id_a[11:4], id_b[19:12], places[23:20]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // status[2:0], entry_id[10:3], position[14:11]
    output logic [4:0]  m_tuser,  // entry_count[4:0]
    output logic        m_tlast
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ril_pkg::state_t state_reg, state_next;

    logic [3:0]          mode_reg;
    logic [ID_WIDTH-1:0] a_reg, b_reg;
    logic [3:0]          places_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                fa_reg, fb_reg;
    logic [IDX_W-1:0]    pa_reg, pb_reg;
    logic [IDX_W-1:0]    walk_reg, walk_next;

    logic [2:0]          st_reg, st_next;
    logic [7:0]          eid_reg, eid_next;
    logic [3:0]          pos_reg, pos_next;
    logic                last_reg, last_next;
    logic [4:0]          cnt_out_reg, cnt_out_next;
    logic                ov_reg, ov_next;

    ril_pkg::edit_t      edit;
    logic [IDX_W-1:0]    lo, hi;
    logic [ID_WIDTH-1:0] wr_id, alt_id;

    logic [ID_WIDTH-1:0] ids [DEPTH];
    logic [DEPTH-1:0]    hit_a, hit_b;
    logic                any_a, any_b;
    logic [IDX_W-1:0]    enc_a, enc_b;

    logic [3:0]          s_mode;
    logic [ID_WIDTH-1:0] s_a, s_b;
    assign s_mode = s_tdata[3:0];
    assign s_a    = ID_WIDTH'(s_tdata[11:4]);
    assign s_b    = ID_WIDTH'(s_tdata[19:12]);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            ril_cell #(.IDX_W(IDX_W), .ID_WIDTH(ID_WIDTH)) u_cell (
                .aclk     (aclk),
                .my_idx   (IDX_W'(g)),
                .in_use   (CNT_W'(g) < count_reg),
                .edit     (edit),
                .lo       (lo),
                .hi       (hi),
                .wr_id    (wr_id),
                .alt_id   (alt_id),
                .key_a    (a_reg),
                .key_b    (b_reg),
                .left_id  (ids[(g == 0) ? 0 : g - 1]),
                .right_id (ids[(g == DEPTH - 1) ? DEPTH - 1 : g + 1]),
                .id_out   (ids[g]),
                .hit_a    (hit_a[g]),
                .hit_b    (hit_b[g])
            );
        end
    endgenerate

    // IDs are unique, so at most one hit: OR-encode.
    always_comb begin
        enc_a = '0;
        enc_b = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (hit_a[i]) enc_a = enc_a | IDX_W'(i);
            if (hit_b[i]) enc_b = enc_b | IDX_W'(i);
        end
        any_a = |hit_a;
        any_b = |hit_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ril_pkg::S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg   <= s_mode;
            a_reg      <= s_a;
            b_reg      <= s_b;
            places_reg <= s_tdata[23:20];
        end
        if (state_reg == ril_pkg::S_SEARCH) begin
            fa_reg <= any_a;
            fb_reg <= any_b;
            pa_reg <= enc_a;
            pb_reg <= enc_b;
        end
        walk_reg    <= walk_next;
        st_reg      <= st_next;
        eid_reg     <= eid_next;
        pos_reg     <= pos_next;
        last_reg    <= last_next;
        cnt_out_reg <= cnt_out_next;
    end

    // result registers are reused by the next command; wait until taken
    assign s_tready = (state_reg == ril_pkg::S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, pos_reg, eid_reg, st_reg};
    assign m_tuser  = cnt_out_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        logic [CNT_W-1:0] room;
        logic [CNT_W-1:0] tgt;
        logic             full;
        room = '0;
        tgt  = '0;
        full = (count_reg >= CNT_W'(DEPTH));

        state_next   = state_reg;
        count_next   = count_reg;
        ov_next      = ov_reg;
        walk_next    = walk_reg;
        st_next      = st_reg;
        eid_next     = eid_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        cnt_out_next = cnt_out_reg;
        edit         = ril_pkg::ED_NONE;
        lo           = '0;
        hi           = '0;
        wr_id        = a_reg;
        alt_id       = b_reg;

        if (ov_reg && m_tready) ov_next = 1'b0;

        case (state_reg)
            ril_pkg::S_IDLE: begin
                if (s_tvalid && s_tready) state_next = ril_pkg::S_SEARCH;
            end
            ril_pkg::S_SEARCH: begin
                walk_next  = '0;
                state_next = (mode_reg == ril_pkg::OP_LIST) ? ril_pkg::S_LIST
                                                            : ril_pkg::S_APPLY;
            end
            ril_pkg::S_APPLY: begin
                st_next = ril_pkg::ST_OK;
                case (mode_reg)
                    ril_pkg::OP_APPEND, ril_pkg::OP_PREPEND: begin
                        if (full) st_next = ril_pkg::ST_FULL;
                        else if (fa_reg) st_next = ril_pkg::ST_DUP;
                        else begin
                            edit = ril_pkg::ED_OPEN;
                            lo = (mode_reg == ril_pkg::OP_APPEND) ? IDX_W'(count_reg) : '0;
                            hi = IDX_W'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ril_pkg::OP_INSERT: begin
                        if (count_reg == '0) st_next = ril_pkg::ST_EMPTY;
                        else if (fa_reg) st_next = ril_pkg::ST_DUP;
                        else if (!fb_reg) st_next = ril_pkg::ST_MISSING;
                        else if (full) st_next = ril_pkg::ST_FULL;
                        else begin
                            edit = ril_pkg::ED_OPEN;
                            lo = pb_reg + 1'b1;
                            hi = IDX_W'(count_reg);
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ril_pkg::OP_FWD, ril_pkg::OP_FRONT: begin
                        if (count_reg == '0) st_next = ril_pkg::ST_EMPTY;
                        else if (!fa_reg) st_next = ril_pkg::ST_MISSING;
                        else if (pa_reg == '0) st_next = ril_pkg::ST_AT_TOP;
                        else begin
                            if (mode_reg == ril_pkg::OP_FRONT
                                || CNT_W'(places_reg) > CNT_W'(pa_reg))
                                tgt = '0;
                            else tgt = CNT_W'(pa_reg) - CNT_W'(places_reg);
                            edit = ril_pkg::ED_UP;
                            lo = IDX_W'(tgt);
                            hi = pa_reg;
                        end
                    end
                    ril_pkg::OP_BACK, ril_pkg::OP_TAIL: begin
                        room = count_reg - 1'b1 - CNT_W'(pa_reg);
                        if (count_reg == '0) st_next = ril_pkg::ST_EMPTY;
                        else if (!fa_reg) st_next = ril_pkg::ST_MISSING;
                        else if (room == '0) st_next = ril_pkg::ST_AT_BOT;
                        else begin
                            if (mode_reg == ril_pkg::OP_TAIL || CNT_W'(places_reg) > room)
                                tgt = count_reg - 1'b1;
                            else tgt = CNT_W'(pa_reg) + CNT_W'(places_reg);
                            edit = ril_pkg::ED_DOWN;
                            lo = pa_reg;
                            hi = IDX_W'(tgt);
                        end
                    end
                    ril_pkg::OP_DELETE: begin
                        if (count_reg == '0) st_next = ril_pkg::ST_EMPTY;
                        else if (!fa_reg) st_next = ril_pkg::ST_MISSING;
                        else begin
                            edit = ril_pkg::ED_DOWN;
                            lo = pa_reg;
                            hi = IDX_W'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                        end
                    end
                    ril_pkg::OP_SWAP: begin
                        if (count_reg == '0) st_next = ril_pkg::ST_EMPTY;
                        else if (!fa_reg || !fb_reg) st_next = ril_pkg::ST_MISSING;
                        else begin
                            edit = ril_pkg::ED_SWAP;
                            lo = pa_reg;
                            hi = pb_reg;
                        end
                    end
                    default: st_next = ril_pkg::ST_OK;
                endcase
                eid_next     = '0;
                pos_next     = '0;
                last_next    = 1'b1;
                cnt_out_next = 5'(count_next);
                state_next   = ril_pkg::S_RESULT;
            end
            ril_pkg::S_RESULT: begin
                // results register loaded; hand it out
                ov_next    = 1'b1;
                state_next = ril_pkg::S_IDLE;
            end
            ril_pkg::S_LIST: begin
                if (!ov_reg || m_tready) begin
                    cnt_out_next = 5'(count_reg);
                    last_next    = 1'b1;
                    pos_next     = 4'(walk_reg);
                    if (count_reg == '0) begin
                        st_next    = ril_pkg::ST_EMPTY;
                        eid_next   = '0;
                        ov_next    = 1'b1;
                        state_next = ril_pkg::S_IDLE;
                    end else begin
                        // cell 0 always holds the next entry; rotate the used part
                        st_next   = ril_pkg::ST_OK;
                        eid_next  = 8'(ids[0]);
                        last_next = (CNT_W'(walk_reg) + 1'b1 == count_reg);
                        ov_next   = 1'b1;
                        edit      = ril_pkg::ED_ROTATE;
                        hi        = IDX_W'(count_reg - 1'b1);
                        wr_id     = ids[0];
                        walk_next = walk_reg + 1'b1;
                        if (last_next) state_next = ril_pkg::S_IDLE;
                    end
                end
            end
            default: state_next = ril_pkg::S_IDLE;
        endcase
    end

endmodule

### hdl/ril_checker.sv
// ----------------------------------------------------------------------------
// ril_checker: port-level checks for the reorderable ID list
// Watches both streams and the entry count reported on results.
// ----------------------------------------------------------------------------
module ril_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tlast, m_tuser, m_tdata}))
        else $error("result changed while stalled");

    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("new command taken during a list");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd7)
        else $error("bad status code");

    a_nonlist_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2:0] != 3'd0 |-> m_tdata[10:3] == 8'd0 && m_tlast)
        else $error("error result carries an entry");

    a_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("two commands taken back to back");

endmodule

bind reorderable_id_list ril_checker u_ril_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
